>>> rtl/drc_pkg.sv
package drc_pkg;

  localparam int MaxRegions = 32;
  localparam int TableDepth = MaxRegions + 1;
  localparam int CoordBits  = 12;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = $clog2(TableDepth + 1);
  localparam int AreaBits   = 2 * CoordBits;
  localparam int AccBits    = AreaBits + $clog2(TableDepth);

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [2:0] {
    REQ_REGION  = 3'd0,
    REQ_FULL    = 3'd1,
    REQ_OVERLAY = 3'd2,
    REQ_CANCEL  = 3'd3,
    REQ_SUBMIT  = 3'd4
  } req_type_e;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    coord_t      start_row;
    coord_t      end_row;
    coord_t      start_col;
    coord_t      end_col;
    logic [31:0] revision;
  } req_t;

  typedef struct packed {
    logic        region_valid;
    coord_t      out_start_row;
    coord_t      out_end_row;
    coord_t      out_start_col;
    coord_t      out_end_col;
    logic        full_frame;
    logic        overlay_dirty;
    logic [31:0] content_revision;
    logic        last;
  } rsp_t;

  typedef struct packed {
    coord_t r0;
    coord_t r1;
    coord_t c0;
    coord_t c1;
  } rect_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APPEND,
    ST_M_RDA,
    ST_M_LDA,
    ST_M_RDB,
    ST_M_CMP,
    ST_M_WB,
    ST_SH_RD,
    ST_SH_WR,
    ST_AR_SCR,
    ST_AR_SCR2,
    ST_AR_RD,
    ST_AR_MUL,
    ST_AR_ACC,
    ST_AR_CHK,
    ST_S_RD,
    ST_S_LD,
    ST_S_WAIT
  } state_e;

endpackage

>>> rtl/dirty_rect_coalescer.sv
// Dirty-rectangle coalescer. A region transaction is clamped to the viewport,
// appended to a 33-entry table and merged pairwise in table order until no
// two rectangles touch; afterwards the covered area is summed and the table
// collapses into a full-frame redraw above 32 entries or at 60 % coverage.
// All work runs through one table RAM, with one read and one write port, and one
// 12x12 multiplier, so a region transaction that is recorded holds in_ready_o
// low while it is appended, while rows are scanned and pairs compared, while
// entries are shifted down after merges and while the final table's area is
// summed. Other requests, and regions that are dropped or only raise the
// revision, are taken back to back. A submit with work pending holds
// in_ready_o low while each region result is read from the table and loaded,
// and while every emitted result is held until the output accepts it.
// Configuration writes are taken only while the block is idle.
module dirty_rect_coalescer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  drc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output drc_pkg::rsp_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  drc_pkg::coord_t cfg_data_i
);
  import drc_pkg::*;

  state_e state_q, state_d;
  logic [CntBits-1:0] count_q, count_d;
  logic full_q, full_d, ovl_q, ovl_d;
  logic [31:0] rev_q, rev_d;
  coord_t cols_q, cols_d, rows_q, rows_d;
  logic [IdxBits-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  rect_t a_q, a_d, new_q, new_d;
  logic [AreaBits-1:0] prod_q, prod_d, scr_q, scr_d;
  logic [AccBits-1:0] acc_q, acc_d;
  rsp_t out_q, out_d;

  rect_t mem [TableDepth];
  rect_t rdata_q;
  logic mem_we;
  logic [IdxBits-1:0] mem_waddr, mem_raddr;
  rect_t mem_wdata;

  coord_t mul_a, mul_b;
  rect_t clamped, merged;
  logic touch, ok_region;
  logic [IdxBits-1:0] cnt_idx;
  logic [AccBits+2:0] dirty5, screen3;

  function automatic coord_t clamp_to(coord_t v, coord_t hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic rects_touch(rect_t a, rect_t b);
    logic row_ov, col_ov, row_adj, col_adj;
    row_ov  = (a.r0 < b.r1) && (b.r0 < a.r1);
    col_ov  = (a.c0 < b.c1) && (b.c0 < a.c1);
    row_adj = (a.r1 == b.r0) || (b.r1 == a.r0);
    col_adj = (a.c1 == b.c0) || (b.c1 == a.c0);
    return (row_ov && col_ov) || (row_adj && col_ov) || (col_adj && row_ov);
  endfunction

  assign cnt_idx = count_q[IdxBits-1:0];

  always_comb begin
    clamped.r0 = clamp_to(in_data_i.start_row, rows_q);
    clamped.r1 = clamp_to(in_data_i.end_row, rows_q);
    clamped.c0 = clamp_to(in_data_i.start_col, cols_q);
    clamped.c1 = clamp_to(in_data_i.end_col, cols_q);
    ok_region  = (cols_q != '0) && (rows_q != '0) &&
                 (clamped.r0 < clamped.r1) && (clamped.c0 < clamped.c1);
  end

  always_comb begin
    touch     = rects_touch(a_q, rdata_q);
    merged.r0 = (rdata_q.r0 < a_q.r0) ? rdata_q.r0 : a_q.r0;
    merged.r1 = (rdata_q.r1 > a_q.r1) ? rdata_q.r1 : a_q.r1;
    merged.c0 = (rdata_q.c0 < a_q.c0) ? rdata_q.c0 : a_q.c0;
    merged.c1 = (rdata_q.c1 > a_q.c1) ? rdata_q.c1 : a_q.c1;
  end

  always_comb begin
    if (state_q == ST_AR_SCR) begin
      mul_a = cols_q;
      mul_b = rows_q;
    end else begin
      mul_a = rdata_q.r1 - rdata_q.r0;
      mul_b = rdata_q.c1 - rdata_q.c0;
    end
  end

  assign dirty5  = (AccBits+3)'({acc_q, 2'b00}) + (AccBits+3)'(acc_q);
  assign screen3 = (AccBits+3)'({scr_q, 1'b0}) + (AccBits+3)'(scr_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.req_type == REQ_REGION && ok_region && !full_q) begin
            state_d = ST_APPEND;
          end else if (in_data_i.req_type == REQ_SUBMIT &&
                       (full_q || ovl_q || count_q != '0)) begin
            state_d = (count_q == '0) ? ST_S_WAIT : ST_S_RD;
          end
        end
      end
      ST_APPEND: state_d = ST_M_RDA;
      ST_M_RDA: begin
        if (CntBits'(i_q) + 1'b1 >= count_q) state_d = ST_AR_SCR;
        else state_d = ST_M_LDA;
      end
      ST_M_LDA: state_d = ST_M_RDB;
      ST_M_RDB: state_d = ST_M_CMP;
      ST_M_CMP: begin
        if (touch) state_d = ST_M_WB;
        else if (CntBits'(j_q) + 1'b1 < count_q) state_d = ST_M_RDB;
        else state_d = ST_M_RDA;
      end
      ST_M_WB: begin
        if (CntBits'(j_q) + 1'b1 < count_q) state_d = ST_SH_RD;
        else state_d = ST_M_RDA;
      end
      ST_SH_RD: state_d = ST_SH_WR;
      ST_SH_WR: begin
        if (CntBits'(k_q) + 2'd2 < count_q) state_d = ST_SH_RD;
        else state_d = ST_M_RDA;
      end
      ST_AR_SCR:  state_d = ST_AR_SCR2;
      ST_AR_SCR2: state_d = (count_q == '0) ? ST_AR_CHK : ST_AR_RD;
      ST_AR_RD:   state_d = ST_AR_MUL;
      ST_AR_MUL:  state_d = ST_AR_ACC;
      ST_AR_ACC: begin
        if (CntBits'(k_q) + 1'b1 < count_q) state_d = ST_AR_RD;
        else state_d = ST_AR_CHK;
      end
      ST_AR_CHK: state_d = ST_IDLE;
      ST_S_RD:   state_d = ST_S_LD;
      ST_S_LD:   state_d = ST_S_WAIT;
      ST_S_WAIT: begin
        if (out_ready_i) state_d = out_q.last ? ST_IDLE : ST_S_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    count_d = count_q; full_d = full_q; ovl_d = ovl_q; rev_d = rev_q;
    cols_d = cols_q; rows_d = rows_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    a_d = a_q; new_d = new_q;
    prod_d = prod_q; scr_d = scr_q; acc_d = acc_q;
    out_d = out_q;
    mem_we = 1'b0; mem_waddr = cnt_idx; mem_wdata = new_q; mem_raddr = i_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            REQ_REGION: begin
              if (ok_region) begin
                if (in_data_i.revision > rev_q) rev_d = in_data_i.revision;
                new_d = clamped;
              end
            end
            REQ_FULL: begin
              count_d = '0; full_d = 1'b1; ovl_d = 1'b1;
              if (in_data_i.revision > rev_q) rev_d = in_data_i.revision;
            end
            REQ_OVERLAY: ovl_d = 1'b1;
            REQ_CANCEL: begin
              count_d = '0; full_d = 1'b0; ovl_d = 1'b0; rev_d = '0;
            end
            REQ_SUBMIT: begin
              k_d = '0;
              out_d = '0;
              out_d.full_frame       = full_q;
              out_d.overlay_dirty    = ovl_q;
              out_d.content_revision = rev_q;
              out_d.last             = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        mem_we = 1'b1;
        count_d = count_q + 1'b1;
        i_d = '0;
      end
      ST_M_RDA: mem_raddr = i_q;
      ST_M_LDA: begin
        a_d = rdata_q;
        j_d = i_q + 1'b1;
      end
      ST_M_RDB: mem_raddr = j_q;
      ST_M_CMP: begin
        if (touch) begin
          a_d = merged;
        end else if (CntBits'(j_q) + 1'b1 < count_q) begin
          j_d = j_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_M_WB: begin
        mem_we = 1'b1; mem_waddr = i_q; mem_wdata = a_q;
        k_d = j_q;
        if (!(CntBits'(j_q) + 1'b1 < count_q)) begin
          count_d = count_q - 1'b1;
          i_d = '0;
        end
      end
      ST_SH_RD: mem_raddr = k_q + 1'b1;
      ST_SH_WR: begin
        mem_we = 1'b1; mem_waddr = k_q; mem_wdata = rdata_q;
        k_d = k_q + 1'b1;
        if (!(CntBits'(k_q) + 2'd2 < count_q)) begin
          count_d = count_q - 1'b1;
          i_d = '0;
        end
      end
      ST_AR_SCR: prod_d = mul_a * mul_b;
      ST_AR_SCR2: begin
        scr_d = prod_q;
        acc_d = '0;
        k_d = '0;
      end
      ST_AR_RD:  mem_raddr = k_q;
      ST_AR_MUL: prod_d = mul_a * mul_b;
      ST_AR_ACC: begin
        acc_d = acc_q + AccBits'(prod_q);
        k_d = k_q + 1'b1;
      end
      ST_AR_CHK: begin
        if (count_q > CntBits'(MaxRegions) || dirty5 >= screen3) begin
          count_d = '0;
          full_d = 1'b1;
        end
      end
      ST_S_RD: mem_raddr = k_q;
      ST_S_LD: begin
        out_d.region_valid  = 1'b1;
        out_d.out_start_row = rdata_q.r0;
        out_d.out_end_row   = rdata_q.r1;
        out_d.out_start_col = rdata_q.c0;
        out_d.out_end_col   = rdata_q.c1;
        out_d.last          = (CntBits'(k_q) + 1'b1 == count_q);
      end
      ST_S_WAIT: begin
        if (out_ready_i) begin
          k_d = k_q + 1'b1;
          if (out_q.last) begin
            count_d = '0; full_d = 1'b0; ovl_d = 1'b0; rev_d = '0;
          end
        end
      end
      default: ;
    endcase

    // a changed viewport forces a full redraw
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_COLUMNS && cfg_data_i != cols_q) begin
        cols_d = cfg_data_i;
        count_d = '0; full_d = 1'b1; ovl_d = 1'b1;
      end else if (cfg_index_i == CFG_ROWS && cfg_data_i != rows_q) begin
        rows_d = cfg_data_i;
        count_d = '0; full_d = 1'b1; ovl_d = 1'b1;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_S_WAIT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      full_q  <= 1'b0;
      ovl_q   <= 1'b0;
      rev_q   <= '0;
      cols_q  <= '0;
      rows_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      full_q  <= full_d;
      ovl_q   <= ovl_d;
      rev_q   <= rev_d;
      cols_q  <= cols_d;
      rows_q  <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    a_q    <= a_d;
    new_q  <= new_d;
    prod_q <= prod_d;
    scr_q  <= scr_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import drc_pkg::*;

  class frame_scoreboard;
    rect_t       tbl[TableDepth];
    int unsigned cnt;
    bit          full_pend;
    bit          ovl_pend;
    logic [31:0] pend_rev;
    int unsigned cols;
    int unsigned rows;
    rsp_t        frame_q[$];
    int          errors;
    int          results;
    int          frames;

    function new();
      cnt = 0;
      full_pend = 0;
      ovl_pend = 0;
      pend_rev = '0;
      cols = 0;
      rows = 0;
      errors = 0;
      results = 0;
      frames = 0;
    endfunction

    function void redraw_all();
      cnt = 0;
      full_pend = 1;
      ovl_pend = 1;
    endfunction

    function void write_cfg(logic [1:0] idx, coord_t v);
      if (idx == CFG_COLUMNS && v != cols) begin
        cols = v;
        redraw_all();
      end else if (idx == CFG_ROWS && v != rows) begin
        rows = v;
        redraw_all();
      end
    endfunction

    function bit touches(rect_t a, rect_t b);
      bit row_ov, col_ov, row_adj, col_adj;
      row_ov  = a.r0 < b.r1 && b.r0 < a.r1;
      col_ov  = a.c0 < b.c1 && b.c0 < a.c1;
      row_adj = a.r1 == b.r0 || b.r1 == a.r0;
      col_adj = a.c1 == b.c0 || b.c1 == a.c0;
      return (row_ov && col_ov) || (row_adj && col_ov) || (col_adj && row_ov);
    endfunction

    // merge first touching pair in table order, restart until stable
    function void coalesce();
      bit changed;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int i = 0; i < cnt && !changed; i++) begin
          for (int j = i + 1; j < cnt; j++) begin
            if (touches(tbl[i], tbl[j])) begin
              if (tbl[j].r0 < tbl[i].r0) tbl[i].r0 = tbl[j].r0;
              if (tbl[j].r1 > tbl[i].r1) tbl[i].r1 = tbl[j].r1;
              if (tbl[j].c0 < tbl[i].c0) tbl[i].c0 = tbl[j].c0;
              if (tbl[j].c1 > tbl[i].c1) tbl[i].c1 = tbl[j].c1;
              for (int k = j; k + 1 < cnt; k++) tbl[k] = tbl[k+1];
              cnt--;
              changed = 1;
              break;
            end
          end
        end
      end
    endfunction

    function bit too_dirty();
      longint unsigned screen, dirty;
      screen = longint'(cols) * rows;
      dirty = 0;
      if (cnt > MaxRegions) return 1;
      if (screen == 0) return 0;
      for (int i = 0; i < cnt; i++)
        dirty += longint'(tbl[i].r1 - tbl[i].r0) * longint'(tbl[i].c1 - tbl[i].c0);
      return 5 * dirty >= 3 * screen;
    endfunction

    function void note_input(req_t r);
      rect_t c;
      rsp_t  o;
      int    n;
      case (r.req_type)
        REQ_REGION: begin
          if (cols != 0 && rows != 0) begin
            c.r0 = (r.start_row > rows) ? coord_t'(rows) : r.start_row;
            c.r1 = (r.end_row   > rows) ? coord_t'(rows) : r.end_row;
            c.c0 = (r.start_col > cols) ? coord_t'(cols) : r.start_col;
            c.c1 = (r.end_col   > cols) ? coord_t'(cols) : r.end_col;
            if (c.r0 < c.r1 && c.c0 < c.c1) begin
              if (r.revision > pend_rev) pend_rev = r.revision;
              if (!full_pend) begin
                if (cnt < TableDepth) begin
                  tbl[cnt] = c;
                  cnt++;
                end
                coalesce();
                if (too_dirty()) begin
                  cnt = 0;
                  full_pend = 1;
                end
              end
            end
          end
        end
        REQ_FULL: begin
          redraw_all();
          if (r.revision > pend_rev) pend_rev = r.revision;
        end
        REQ_OVERLAY: ovl_pend = 1;
        REQ_CANCEL: begin
          cnt = 0;
          full_pend = 0;
          ovl_pend = 0;
          pend_rev = '0;
        end
        REQ_SUBMIT: begin
          if (full_pend || ovl_pend || cnt != 0) begin
            frames++;
            n = (cnt > MaxRegions) ? MaxRegions : cnt;
            o = '0;
            o.full_frame = full_pend;
            o.overlay_dirty = ovl_pend;
            o.content_revision = pend_rev;
            if (n == 0) begin
              o.last = 1;
              frame_q = {frame_q, o};
            end else begin
              for (int k = 0; k < n; k++) begin
                o.region_valid = 1;
                o.out_start_row = tbl[k].r0;
                o.out_end_row = tbl[k].r1;
                o.out_start_col = tbl[k].c0;
                o.out_end_col = tbl[k].c1;
                o.last = (k + 1 == n);
                frame_q = {frame_q, o};
              end
            end
            cnt = 0;
            full_pend = 0;
            ovl_pend = 0;
            pend_rev = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      results++;
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = frame_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("ERROR: result mismatch\n  exp %p\n  got %p", want, got);
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid = 0;
  logic       in_ready;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  rsp_t       out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  coord_t     cfg_data = '0;

  frame_scoreboard sb = new();
  bit idle_en = 1;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int items = 0;

  always #5 clk_i = ~clk_i;

  dirty_rect_coalescer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check(out_data);
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= idle_en ? ($urandom_range(99) >= 16) : 1'b1;
    end
  end

  task automatic send(req_t r);
    if (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_input(r);
    items++;
  endtask

  // wait for every frame result, then for any region transaction still merging
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.frame_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, coord_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.write_cfg(idx, v);
    @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [2:0] t, int r0, int r1, int c0, int c1,
                              logic [31:0] rev);
    req_t r;
    r.req_type = t;
    r.start_row = coord_t'(r0);
    r.end_row = coord_t'(r1);
    r.start_col = coord_t'(c0);
    r.end_col = coord_t'(c1);
    r.revision = rev;
    return r;
  endfunction

  function automatic req_t rand_req(int cols, int rows);
    req_t r;
    int   p, lr, lc, sz;
    r = '0;
    r.revision = $urandom();
    p = $urandom_range(99);
    if (p < 72) begin
      r.req_type = REQ_REGION;
      if ($urandom_range(9) == 0) begin
        r.start_row = coord_t'($urandom());
        r.end_row = coord_t'($urandom());
        r.start_col = coord_t'($urandom());
        r.end_col = coord_t'($urandom());
      end else begin
        lr = (rows + rows / 4 + 1 > 4095) ? 4095 : rows + rows / 4 + 1;
        lc = (cols + cols / 4 + 1 > 4095) ? 4095 : cols + cols / 4 + 1;
        sz = $urandom_range(1, 6);
        r.start_row = coord_t'($urandom_range(lr));
        r.end_row = (r.start_row + sz > 4095) ? 12'd4095 : coord_t'(r.start_row + sz);
        sz = $urandom_range(1, 10);
        r.start_col = coord_t'($urandom_range(lc));
        r.end_col = (r.start_col + sz > 4095) ? 12'd4095 : coord_t'(r.start_col + sz);
      end
    end else if (p < 84) r.req_type = REQ_SUBMIT;
    else if (p < 88) r.req_type = REQ_FULL;
    else if (p < 93) r.req_type = REQ_OVERLAY;
    else if (p < 96) r.req_type = REQ_CANCEL;
    else r.req_type = 3'(REQ_SUBMIT + $urandom_range(1, 3));
    return r;
  endfunction

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int vp[7][2] = '{'{4095, 4095}, '{80, 24}, '{1, 1}, '{0, 30}, '{16, 0},
                     '{200, 60}, '{4095, 1}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    write_reg(CFG_COLUMNS, coord_t'(80));
    write_reg(CFG_ROWS, coord_t'(24));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_REGION, 2, 4, 10, 20, 5));
    send(mk(REQ_REGION, 4, 6, 12, 15, 3));
    send(mk(REQ_REGION, 0, 1, 20, 30, 9));
    send(mk(REQ_REGION, 10, 11, 50, 52, 1));
    send(mk(REQ_REGION, 5, 5, 0, 80, 32'hffff_ffff));
    send(mk(REQ_REGION, 7, 3, 0, 80, 32'hffff_ffff));
    send(mk(REQ_REGION, 30, 4095, 0, 80, 32'hffff_ffff));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_OVERLAY, 0, 0, 0, 0, 0));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_REGION, 0, 4095, 0, 4095, 32'hffff_ffff));
    send(mk(REQ_REGION, 1, 2, 1, 2, 7));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_REGION, 0, 12, 0, 40, 2));
    send(mk(REQ_REGION, 12, 15, 0, 40, 4));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_FULL, 0, 0, 0, 0, 32'h8000_0000));
    send(mk(REQ_FULL, 0, 0, 0, 0, 1));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(REQ_REGION, 0, 2, 0, 2, 6));
    send(mk(REQ_CANCEL, 0, 0, 0, 0, 0));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    send(mk(3'd7, 4095, 4095, 4095, 4095, 32'hffff_ffff));
    send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_COLUMNS, coord_t'(vp[ph][0]));
      write_reg(CFG_ROWS, coord_t'(vp[ph][1]));
      if (ph == 1) begin
        write_reg(CFG_ROWS, coord_t'(vp[ph][1]));  // same value: no redraw
        write_reg(2'd3, 12'hfff);
      end
      idle_en = (ph != 5);
      if (ph == 2) begin
        // stall the output while submits keep coming
        hold_token++;
        repeat (15) send(mk(REQ_FULL, 0, 0, 0, 0, $urandom()));
        repeat (15) begin
          send(mk(REQ_OVERLAY, 0, 0, 0, 0, 0));
          send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
        end
      end
      repeat (40) send(rand_req(vp[ph][0], vp[ph][1]));
      send(mk(REQ_SUBMIT, 0, 0, 0, 0, 0));
      drain();
    end
    idle_en = 1;

    $display("Run: %0d transactions sent, %0d frames and %0d results checked",
             items, sb.frames, sb.results);
    $display("  over 7 viewport settings incl. disabled, 1x1 and 4095x4095");
    if (sb.frame_q.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", sb.frame_q.size());
      sb.errors += sb.frame_q.size();
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/drc_pkg.sv
rtl/dirty_rect_coalescer.sv
dv/tb.sv
